FILE: rtl/lnr_pkg.sv
// Package: shared types and constants of the noise reducer.
`default_nettype none
package lnr_pkg;
    localparam int SAMPLE_W = 16;
    localparam int COEF_W   = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENABLE    = 3'd0,
        REG_RATE      = 3'd1,
        REG_LEAK      = 3'd2,
        REG_TAP_COUNT = 3'd3,
        REG_TAP_DELAY = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] in_real;
        logic signed [SAMPLE_W-1:0] in_imag;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] out_real;
        logic signed [SAMPLE_W-1:0] out_imag;
    } t_out_item;
endpackage
`default_nettype wire

FILE: rtl/lnr_in_if.sv
// Interface: input sample channel.
`default_nettype none
interface lnr_in_if;
    logic                     valid;
    logic                     ready;
    lnr_pkg::t_in_item        data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/lnr_out_if.sv
// Interface: output sample channel.
`default_nettype none
interface lnr_out_if;
    logic                     valid;
    logic                     ready;
    lnr_pkg::t_out_item       data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/leaky_nlms_noise_reducer.sv
// Top level: leaky normalized LMS adaptive line enhancer.
//
//  channel   dir  handshake        payload
//  s_in      in   valid/ready      in_real, in_imag (Q1.15)
//  m_out     out  valid/ready      out_real, out_imag (Q1.15)
//  cfg       in   i_cfg_we         i_cfg_idx, i_cfg_data
//
// Enabled: from acceptance to output valid the block runs a read pass over
// the taps, a normalizing divide, and an update pass over the taps. The sample
// enters the line RAM at acceptance. Disabled: output valid the cycle after
// acceptance. After each output transaction the block returns to idle. After
// reset, or a tap_count/tap_delay write, a clear pass sweeps the line and
// coefficient RAMs; no transaction is taken meanwhile. A stalled output holds
// the block.
`default_nettype none
module leaky_nlms_noise_reducer #(
    parameter int LINE_DEPTH = 256,
    parameter int MAX_TAPS   = 64
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [lnr_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [lnr_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    lnr_in_if.sink                                 s_in,
    lnr_out_if.source                              m_out
);
    import lnr_pkg::*;

    localparam int LA_W = $clog2(LINE_DEPTH);
    localparam int CA_W = $clog2(MAX_TAPS);
    localparam int CNT_W = $clog2(MAX_TAPS + 1);
    localparam int CLR_N = (LINE_DEPTH > MAX_TAPS) ? LINE_DEPTH : MAX_TAPS;
    localparam int CLR_W = $clog2(CLR_N + 1);

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_ACC_RD, ST_ACC, ST_POST, ST_DIV, ST_DIVW,
        ST_UPD_RD, ST_UPD_M1, ST_UPD_M2, ST_UPD_WR, ST_OUT
    } t_state;

    t_state r_state;

    // configuration
    logic        r_en;
    logic [15:0] r_rate, r_leak;
    logic [6:0]  r_tcount;
    logic [7:0]  r_tdelay;
    logic        r_clr_req;

    logic [LA_W-1:0]   r_wp;
    logic [CLR_W-1:0]  r_clr;
    logic [CNT_W-1:0]  r_j, r_taps;
    logic signed [15:0] r_xr;
    logic signed [63:0] r_acc;
    logic [39:0]        r_sq;
    logic signed [47:0] r_g;
    logic [23:0]        r_d;
    logic signed [31:0] r_c;
    logic signed [15:0] r_x;
    logic signed [63:0] r_p1, r_p2;
    logic signed [15:0] r_or, r_oi;

    // RAMs
    logic               w_lwe, w_cwe;
    logic [LA_W-1:0]    w_lwa, w_lra;
    logic [CA_W-1:0]    w_cwa, w_cra;
    logic [15:0]        w_lwd, w_lrd;
    logic [31:0]        w_cwd, w_crd;

    lnr_ram #(.WIDTH(16), .DEPTH(LINE_DEPTH)) u_line (
        .i_clk(i_clk), .i_we(w_lwe), .i_waddr(w_lwa), .i_wdata(w_lwd),
        .i_raddr(w_lra), .o_rdata(w_lrd));
    lnr_ram #(.WIDTH(32), .DEPTH(MAX_TAPS)) u_coef (
        .i_clk(i_clk), .i_we(w_cwe), .i_waddr(w_cwa), .i_wdata(w_cwd),
        .i_raddr(w_cra), .o_rdata(w_crd));

    // divider
    logic               r_dstart, w_ddone;
    logic signed [63:0] w_dq, w_num;
    lnr_div #(.NUM_W(64), .DEN_W(40)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_dstart), .i_num(w_num),
        .i_den(r_sq + 40'd1), .o_done(w_ddone), .o_quo(w_dq));

    // error term, numerator e*rate*2^26
    logic signed [63:0] w_r28, w_r29;
    logic signed [63:0] w_e;
    always_comb begin
        w_r28 = (r_acc + 64'sd134217728) >>> 28;
        w_r29 = (r_acc * 64'sd3 + 64'sd268435456) >>> 29;
        w_e   = 64'(r_xr) - w_r28;
        if (w_e < -64'sd1048576) w_e = -64'sd1048576;
        else if (w_e > 64'sd1048575) w_e = 64'sd1048575;
    end
    logic signed [20:0] r_e;
    logic signed [37:0] w_erate;
    assign w_erate = r_e * $signed({1'b0, r_rate});
    assign w_num   = 64'(w_erate) <<< 26;

    // tap square for the energy sum
    logic signed [31:0] w_x2;
    assign w_x2 = $signed(w_lrd) * $signed(w_lrd);

    // line address for tap j
    logic [LA_W-1:0] w_tap_addr;
    assign w_tap_addr = LA_W'(r_j) + LA_W'(r_tdelay) + r_wp;

    logic w_clr_act;
    assign w_clr_act = (r_state == ST_CLEAR);

    // coefficient update (from products)
    logic signed [63:0] w_nc;
    always_comb begin
        w_nc = 64'(r_c) - ((r_p1 + 64'sd8388608) >>> 24)
             + ((r_p2 + 64'sd8192) >>> 14);
    end

    // saturated new coefficient, written in ST_UPD_WR
    logic signed [31:0] w_nc_sat;
    always_comb begin
        if (w_nc < -64'sd2147483648) w_nc_sat = 32'h8000_0000;
        else if (w_nc > 64'sd2147483647) w_nc_sat = 32'h7fff_ffff;
        else w_nc_sat = w_nc[31:0];
    end

    always_comb begin
        w_lwe = 1'b0; w_lwa = r_wp; w_lwd = s_in.data.in_real;
        w_cwe = 1'b0; w_cwa = r_j[CA_W-1:0]; w_cwd = '0;
        if (w_clr_act) begin
            w_lwe = r_clr < CLR_W'(LINE_DEPTH);
            w_lwa = r_clr[LA_W-1:0];
            w_lwd = '0;
            w_cwe = r_clr < CLR_W'(MAX_TAPS);
            w_cwa = r_clr[CA_W-1:0];
        end else if (r_state == ST_IDLE && s_in.valid && s_in.ready && r_en) begin
            // new sample lands before the first tap read
            w_lwe = 1'b1;
        end else if (r_state == ST_UPD_WR) begin
            w_cwe = 1'b1;
            w_cwd = w_nc_sat;
        end
        w_lra = w_tap_addr;
        w_cra = r_j[CA_W-1:0];
    end

    assign s_in.ready   = (r_state == ST_IDLE) && !r_clr_req && !m_out.valid;
    assign m_out.valid  = (r_state == ST_OUT);
    assign m_out.data.out_real = r_or;
    assign m_out.data.out_imag = r_oi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr     <= '0;
            r_clr_req <= 1'b0;
            r_en      <= 1'b0;
            r_rate    <= 16'd655;
            r_leak    <= 16'd655;
            r_tcount  <= 7'd64;
            r_tdelay  <= 8'd8;
            r_wp      <= '0;
            r_dstart  <= 1'b0;
        end else begin
            r_dstart <= 1'b0;
            if (i_cfg_we) begin
                case (t_reg_idx'(i_cfg_idx))
                    REG_ENABLE:    r_en   <= i_cfg_data[0];
                    REG_RATE:      r_rate <= i_cfg_data;
                    REG_LEAK:      r_leak <= i_cfg_data;
                    REG_TAP_COUNT: begin r_tcount <= i_cfg_data[6:0]; r_clr_req <= 1'b1; end
                    REG_TAP_DELAY: begin r_tdelay <= i_cfg_data[7:0]; r_clr_req <= 1'b1; end
                    default: ;
                endcase
            end
            case (r_state)
                ST_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    r_wp  <= '0;
                    if (r_clr == CLR_W'(CLR_N - 1)) r_state <= ST_IDLE;
                end
                ST_IDLE: begin
                    if (r_clr_req && !i_cfg_we) begin
                        r_clr_req <= 1'b0;
                        r_clr     <= '0;
                        r_state   <= ST_CLEAR;
                    end else if (s_in.valid && s_in.ready) begin
                        r_xr <= s_in.data.in_real;
                        if (!r_en) begin
                            r_or <= s_in.data.in_real;
                            r_oi <= s_in.data.in_imag;
                            r_state <= ST_OUT;
                        end else begin
                            r_taps <= (32'(r_tcount) > 32'(MAX_TAPS)) ? CNT_W'(MAX_TAPS)
                                                                      : CNT_W'(r_tcount);
                            r_j    <= '0;
                            r_acc  <= '0;
                            r_sq   <= '0;
                            r_d    <= 24'((32'(r_rate) * 32'(r_leak)) >> 8);
                            r_state <= ST_ACC_RD;
                        end
                    end
                end
                ST_ACC_RD: begin
                    if (r_j == r_taps) r_state <= ST_POST;
                    else r_state <= ST_ACC;
                end
                ST_ACC: begin
                    r_acc <= r_acc + $signed(w_crd) * $signed(w_lrd);
                    r_sq  <= r_sq + {8'd0, w_x2};
                    r_j   <= r_j + 1'b1;
                    r_state <= ST_ACC_RD;
                end
                ST_POST: begin
                    r_e <= w_e[20:0];
                    if (w_r29 < -64'sd32768) r_or <= -16'sd32768;
                    else if (w_r29 > 64'sd32767) r_or <= 16'sd32767;
                    else r_or <= w_r29[15:0];
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    r_oi     <= r_or;
                    r_dstart <= 1'b1;
                    r_state  <= ST_DIVW;
                end
                ST_DIVW: begin
                    if (w_ddone) begin
                        if (w_dq < -(64'sd1 <<< 46)) r_g <= -(48'sd1 <<< 46);
                        else if (w_dq > (64'sd1 <<< 46)) r_g <= 48'sd1 <<< 46;
                        else r_g <= w_dq[47:0];
                        r_j <= '0;
                        r_state <= ST_UPD_RD;
                    end
                end
                ST_UPD_RD: begin
                    if (r_j == r_taps) begin
                        r_wp <= r_wp - 1'b1;
                        r_state <= ST_OUT;
                    end else r_state <= ST_UPD_M1;
                end
                ST_UPD_M1: begin
                    r_c <= w_crd;
                    r_x <= w_lrd;
                    r_p1 <= $signed(w_crd) * $signed({1'b0, r_d});
                    r_state <= ST_UPD_M2;
                end
                ST_UPD_M2: begin
                    r_p2 <= r_g * r_x;
                    r_state <= ST_UPD_WR;
                end
                ST_UPD_WR: begin
                    // w_nc_sat goes to the coefficient RAM this cycle
                    r_j <= r_j + 1'b1;
                    r_state <= ST_UPD_RD;
                end
                ST_OUT: begin
                    if (m_out.ready) r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

FILE: rtl/lnr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
`default_nettype none
module lnr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

FILE: rtl/lnr_div.sv
// Restoring divider: signed numerator / unsigned divisor, one quotient bit per cycle.
`default_nettype none
module lnr_div #(
    parameter int NUM_W = 64,
    parameter int DEN_W = 40
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_start,
    input  wire logic signed [NUM_W-1:0] i_num,
    input  wire logic [DEN_W-1:0]        i_den,
    output      logic                    o_done,
    output      logic signed [NUM_W-1:0] o_quo
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0]  r_q, n_q;
    logic [DEN_W:0]    r_rem, n_rem;
    logic [DEN_W-1:0]  r_den;
    logic              r_neg;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic [DEN_W:0]    w_trial;

    always_comb begin
        w_trial = {r_rem[DEN_W-1:0], r_q[NUM_W-1]};
        n_q     = {r_q[NUM_W-2:0], 1'b0};
        n_rem   = w_trial;
        if (w_trial >= {1'b0, r_den}) begin
            n_rem = w_trial - {1'b0, r_den};
            n_q[0] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_neg  <= i_num[NUM_W-1];
                r_q    <= i_num[NUM_W-1] ? -i_num : i_num;
                r_rem  <= '0;
                r_den  <= i_den;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_q   <= n_q;
                r_rem <= n_rem;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    assign o_quo = r_neg ? -$signed(r_q) : $signed(r_q);
endmodule
`default_nettype wire

FILE: bench/tb_top.sv
// Testbench: self-checking random and directed test of the noise reducer.
`default_nettype none
module tb_top;
    import lnr_pkg::*;

    // Clock, reset and config port
    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    always #6 i_clk = ~i_clk;

    lnr_in_if  in_ch ();
    lnr_out_if out_ch ();

    leaky_nlms_noise_reducer DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .s_in       (in_ch),
        .m_out      (out_ch)
    );

    localparam int LINE_LEN = 256;
    localparam int TAP_MAX  = 64;
    localparam int STALL_LIMIT = 20000;

    // Shadow of the block: delay line, coefficients, write pointer, registers
    logic signed [15:0] line_mem [LINE_LEN];
    logic signed [31:0] coef_mem [TAP_MAX];
    int unsigned wr_ptr;
    bit          en_r;
    int unsigned rate_r, leak_r, tap_cnt_r, tap_dly_r;

    t_in_item  pend_q [$];     // samples not yet handed to the driver
    t_out_item filt_q [$];     // expected filter outputs, oldest first

    int  src_idle_pct = 0;
    int  snk_idle_pct = 0;
    bit  hold_src = 1'b0;
    int  err_cnt = 0;
    int  quiet_cycles = 0;
    bit  in_fire, out_fire;
    int unsigned tone_ph = 0;
    int unsigned tone_step = 1000;
    int  tone_amp = 16;

    function automatic longint clamp(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic void clear_shadow();
        foreach (line_mem[i]) line_mem[i] = '0;
        foreach (coef_mem[i]) coef_mem[i] = '0;
        wr_ptr = 0;
    endfunction

    function automatic void shadow_reg_write(t_reg_idx idx, logic [15:0] v);
        case (idx)
            REG_ENABLE: en_r = v[0];
            REG_RATE: rate_r = 32'(v);
            REG_LEAK: leak_r = 32'(v);
            REG_TAP_COUNT: begin
                tap_cnt_r = 32'(v[6:0]);
                clear_shadow();
            end
            REG_TAP_DELAY: begin
                tap_dly_r = 32'(v[7:0]);
                clear_shadow();
            end
            default: ;
        endcase
    endfunction

    // One filter step: predict, adapt with leak, step the pointer back; disabled, pass through.
    function automatic t_out_item filter_step(t_in_item s);
        t_out_item r;
        longint acc, sq, p, e, g, d, c, x, nc;
        int taps, k;
        if (!en_r) begin
            r.out_real = s.in_real;
            r.out_imag = s.in_imag;
            return r;
        end
        taps = tap_cnt_r > TAP_MAX ? TAP_MAX : tap_cnt_r;
        line_mem[wr_ptr] = s.in_real;
        acc = 0;
        sq = 0;
        for (int j = 0; j < taps; j++) begin
            k = (j + tap_dly_r + wr_ptr) % LINE_LEN;
            x = line_mem[k];
            sq += x * x;
            acc += longint'(coef_mem[j]) * x;
        end
        p = clamp((acc * 3 + (longint'(1) << 28)) >>> 29, -32768, 32767);
        e = clamp(longint'(s.in_real) - ((acc + (longint'(1) << 27)) >>> 28),
                  -(longint'(1) << 20), (longint'(1) << 20) - 1);
        g = (e * longint'(rate_r) * (longint'(1) << 26)) / (sq + 1);
        g = clamp(g, -(longint'(1) << 46), longint'(1) << 46);
        d = (longint'(rate_r) * longint'(leak_r)) >>> 8;
        for (int j = 0; j < taps; j++) begin
            k = (j + tap_dly_r + wr_ptr) % LINE_LEN;
            x = line_mem[k];
            c = coef_mem[j];
            nc = c - ((c * d + (longint'(1) << 23)) >>> 24)
                   + ((g * x + (longint'(1) << 13)) >>> 14);
            coef_mem[j] = 32'(clamp(nc, -(longint'(1) << 31), (longint'(1) << 31) - 1));
        end
        wr_ptr = (wr_ptr + LINE_LEN - 1) % LINE_LEN;
        r.out_real = p[15:0];
        r.out_imag = p[15:0];
        return r;
    endfunction

    // Noisy triangle tone most of the time, so the filter has a line to lock on;
    // the rest is full-range noise.
    function automatic t_in_item make_sample();
        t_in_item s;
        int tri_v, v;
        s.in_imag = 16'($urandom);
        if ($urandom_range(9) < 3) begin
            s.in_real = 16'($urandom);
        end else begin
            tone_ph = (tone_ph + tone_step) & 16'hFFFF;
            tri_v = tone_ph[15] ? (tone_ph ^ 16'hFFFF) & 16'h7FFF : tone_ph;
            v = ((tri_v - 16384) * tone_amp) / 16 + int'($urandom_range(1024)) - 512;
            s.in_real = 16'(v);
        end
        return s;
    endfunction

    function automatic t_in_item mk(int re, int im);
        t_in_item s;
        s.in_real = 16'(re);
        s.in_imag = 16'(im);
        return s;
    endfunction

    task automatic reg_write(t_reg_idx idx, logic [15:0] v);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= v;
        shadow_reg_write(idx, v);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        wait (pend_q.size() == 0 && !in_ch.valid && filt_q.size() == 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_idling(int mode);
        case (mode % 4)
            0: begin src_idle_pct = 0;  snk_idle_pct = 0;  end
            1: begin src_idle_pct = 72; snk_idle_pct = 0;  end
            2: begin src_idle_pct = 0;  snk_idle_pct = 72; end
            default: begin src_idle_pct = 24; snk_idle_pct = 24; end
        endcase
    endtask

    // Driver: a held transaction stays up until taken; the prediction is made
    // when the transaction is accepted.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            in_fire = in_ch.valid && in_ch.ready;
            if (in_fire) filt_q.push_back(filter_step(in_ch.data));
            if (!in_ch.valid || in_fire) begin
                if (pend_q.size() > 0 && !hold_src
                    && $urandom_range(99) >= src_idle_pct) begin
                    in_ch.data  <= pend_q.pop_front();
                    in_ch.valid <= 1'b1;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare every output transaction with the oldest expectation.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            out_fire = out_ch.valid && out_ch.ready;
            if (out_fire) begin
                if (filt_q.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("tb_top: unexpected output %0d/%0d",
                                 out_ch.data.out_real, out_ch.data.out_imag);
                end else begin
                    t_out_item want;
                    want = filt_q.pop_front();
                    if (want.out_real !== out_ch.data.out_real
                        || want.out_imag !== out_ch.data.out_imag) begin
                        err_cnt++;
                        if (err_cnt <= 10)
                            $display("tb_top: mismatch exp %0d/%0d got %0d/%0d",
                                     want.out_real, want.out_imag,
                                     out_ch.data.out_real, out_ch.data.out_imag);
                    end
                end
            end
            out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // Watchdog on cycles with no transaction and no register write
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || i_cfg_we)
            quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    initial begin
        in_ch.valid = 1'b0;
        in_ch.data  = '0;
        out_ch.ready = 1'b0;
        en_r = 1'b0;
        rate_r = 655;
        leak_r = 655;
        tap_cnt_r = 64;
        tap_dly_r = 8;
        clear_shadow();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: pass-through with extremes on both fields
        pend_q.push_back(mk(-32768, 32767));
        pend_q.push_back(mk(32767, -32768));
        pend_q.push_back(mk(0, -1));
        wait_drained();

        // Reset settings, full 64 taps, extreme samples
        reg_write(REG_ENABLE, 16'd1);
        pend_q.push_back(mk(32767, 0));
        pend_q.push_back(mk(-32768, 1));
        pend_q.push_back(mk(32767, 5));
        pend_q.push_back(mk(-1, -1));
        pend_q.push_back(mk(0, 0));
        wait_drained();

        // Zero taps: outputs zero while the line still fills
        reg_write(REG_TAP_COUNT, 16'd0);
        for (int i = 0; i < 4; i++) pend_q.push_back(mk(20000 - i * 9000, i));
        wait_drained();

        // Tap count beyond the limit and delay that wraps past the line end
        reg_write(REG_RATE, 16'hFFFF);
        reg_write(REG_LEAK, 16'hFFFF);
        reg_write(REG_TAP_COUNT, 16'd127);
        reg_write(REG_TAP_DELAY, 16'd255);
        for (int i = 0; i < 6; i++) pend_q.push_back(mk(i[0] ? 32767 : -32768, 0));
        wait_drained();

        // Minimum rate and leak, single tap, no delay: nothing adapts
        reg_write(REG_RATE, 16'd0);
        reg_write(REG_LEAK, 16'd0);
        reg_write(REG_TAP_COUNT, 16'd1);
        reg_write(REG_TAP_DELAY, 16'd0);
        for (int i = 0; i < 4; i++) pend_q.push_back(mk(i * 8000, -i));
        wait_drained();

        // Random phases: a new setting and idling pattern each time
        for (int ph = 0; ph < 8; ph++) begin
            set_idling(ph);
            reg_write(REG_ENABLE, (ph == 5) ? 16'd0 : 16'd1);
            case ($urandom_range(3))
                0: reg_write(REG_RATE, 16'hFFFF);
                1: reg_write(REG_RATE, 16'd0);
                default: reg_write(REG_RATE, 16'($urandom));
            endcase
            case ($urandom_range(3))
                0: reg_write(REG_LEAK, 16'hFFFF);
                1: reg_write(REG_LEAK, 16'd0);
                default: reg_write(REG_LEAK, 16'($urandom_range(2000)));
            endcase
            // mostly short filters; full length only now and then
            if (ph == 3) reg_write(REG_TAP_COUNT, 16'd64);
            else if (ph == 6) reg_write(REG_TAP_COUNT, 16'd0);
            else reg_write(REG_TAP_COUNT, 16'($urandom_range(1, 8)));
            reg_write(REG_TAP_DELAY, 16'($urandom_range(255)));
            tone_step = $urandom_range(200, 6000);
            tone_amp = $urandom_range(1, 31);
            for (int i = 0; i < 200; i++) begin
                pend_q.push_back(make_sample());
                if (ph == 2 && i == 100) begin
                    // sender holds off until the block has fully drained
                    wait (pend_q.size() == 0);
                    hold_src = 1'b1;
                    wait (!in_ch.valid && filt_q.size() == 0);
                    @(posedge i_clk);
                    hold_src = 1'b0;
                end
            end
            wait_drained();
        end

        repeat (400) @(posedge i_clk);
        if (filt_q.size() != 0) err_cnt++;
        if (err_cnt == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end
endmodule
`default_nettype wire
